[rtl/core/sha256_stream_hasher_defines.svh]
// Assertion macros used by the checker file.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/sha_pkg.sv]
`timescale 1ns / 1ps
package sha_pkg;

   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LenPos     = 56;
   localparam logic [7:0]  PadByte    = 8'h80;

   typedef logic [31:0] word_type;

   // Control from the front end to the round engine.
   typedef struct packed {
      logic start;
      logic final_blk;
   } cmd_type;

   function automatic word_type init_word(input logic [2:0] idx);
      word_type r;
      case (idx)
         3'd0:    r = 32'h6a09e667;
         3'd1:    r = 32'hbb67ae85;
         3'd2:    r = 32'h3c6ef372;
         3'd3:    r = 32'ha54ff53a;
         3'd4:    r = 32'h510e527f;
         3'd5:    r = 32'h9b05688c;
         3'd6:    r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

[rtl/core/sha_round.sv]
`timescale 1ns / 1ps
// Round engine: 16-word schedule window in a shift register, one round per cycle,
// chaining value in a small register file, digest words streamed out.
module sha_round (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::cmd_type       cmd,
   input  logic [31:0]            blk_word,
   output logic [3:0]             blk_addr,
   output logic                   busy,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic [2:0]             rsp_tuser,
   output logic                   rsp_tlast
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_RUN  = 4'b0100,
      ST_OUT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        fin_ff, fin_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in;
   logic [31:0] cv_ff [8];
   logic [31:0] w_ff  [16];
   logic [31:0] wt, s0, s1, t1, t2;

   // Schedule word for the current round from the sliding window, plus the round terms t1 and t2.
   always_comb begin
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
         ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
         ^ (w_ff[14] >> 10);
      wt = (cnt_ff < 7'd16) ? w_ff[0] : (w_ff[0] + s0 + w_ff[9] + s1);
      t1 = h_ff + ({e_ff[5:0], e_ff[31:6]} ^ {e_ff[10:0], e_ff[31:11]}
         ^ {e_ff[24:0], e_ff[31:25]}) + ((e_ff & f_ff) ^ (~e_ff & g_ff))
         + sha_pkg::RoundK[cnt_ff[5:0]] + wt;
      t2 = ({a_ff[1:0], a_ff[31:2]} ^ {a_ff[12:0], a_ff[31:13]}
         ^ {a_ff[21:0], a_ff[31:22]})
         + ((a_ff & b_ff) ^ (a_ff & c_ff) ^ (b_ff & c_ff));
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      fin_in   = fin_ff;
      {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in} =
         {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff};
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_LOAD;
               cnt_in   = '0;
               fin_in   = cmd.final_blk;
            end
         end
         ST_LOAD: begin
            // Buffer read address cnt-1 returns data now.
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd16) begin
               state_in = ST_RUN;
               cnt_in   = '0;
               {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in} =
                  {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3],
                   cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
            end
         end
         ST_RUN: begin
            {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in} =
               {t1 + t2, a_ff, b_ff, c_ff, d_ff + t1, e_ff, f_ff, g_ff};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) begin
               cnt_in   = '0;
               state_in = fin_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               cnt_in = cnt_ff + 7'd1;
               if (cnt_ff == 7'd7) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
      end
      {a_ff, b_ff, c_ff, d_ff, e_ff, f_ff, g_ff, h_ff} <=
         {a_in, b_in, c_in, d_in, e_in, f_in, g_in, h_in};
   end

   // Schedule window: shifts in loaded words, then computed words.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_LOAD && cnt_ff != 7'd0) || state_ff == ST_RUN) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= (state_ff == ST_LOAD) ? blk_word : wt;
      end
   end

   // Chaining value: fold in after 64 rounds, reset after the digest leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            cv_ff[i] <= sha_pkg::init_word(3'(i));
         end
      end else if (state_ff == ST_RUN && cnt_ff == 7'd63) begin
         cv_ff[0] <= cv_ff[0] + t1 + t2;
         cv_ff[1] <= cv_ff[1] + a_ff;
         cv_ff[2] <= cv_ff[2] + b_ff;
         cv_ff[3] <= cv_ff[3] + c_ff;
         cv_ff[4] <= cv_ff[4] + d_ff + t1;
         cv_ff[5] <= cv_ff[5] + e_ff;
         cv_ff[6] <= cv_ff[6] + f_ff;
         cv_ff[7] <= cv_ff[7] + g_ff;
      end else if (state_ff == ST_OUT && rsp_tready && cnt_ff == 7'd7) begin
         for (int i = 0; i < 8; i++) begin
            cv_ff[i] <= sha_pkg::init_word(3'(i));
         end
      end
   end

   assign blk_addr   = cnt_ff[3:0];
   assign busy       = (state_ff != ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = cv_ff[cnt_ff[2:0]];
   assign rsp_tuser  = cnt_ff[2:0];
   assign rsp_tlast  = (cnt_ff[2:0] == 3'd7);

endmodule

[rtl/core/sha_buffer.sv]
`timescale 1ns / 1ps
// Block buffer: byte memory per lane, plus padding sequencer.
module sha_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tuser,
   input  logic             req_tlast,
   input  logic             eng_busy,
   input  logic [3:0]       eng_addr,
   output logic [31:0]      eng_word,
   output sha_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_ACC  = 4'b0001,
      ST_PAD  = 4'b0010,
      ST_LEN  = 4'b0100,
      ST_WAIT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        last_ff, last_in;
   logic        pad_ff, pad_in;
   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic [7:0]  mem0 [16];
   logic [7:0]  mem1 [16];
   logic [7:0]  mem2 [16];
   logic [7:0]  mem3 [16];
   logic [7:0]  rd0_ff, rd1_ff, rd2_ff, rd3_ff;
   logic        acc;

   assign req_tready = (state_ff == ST_ACC) && !eng_busy;
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      bits_in  = bits_ff;
      last_in  = last_ff;
      pad_in   = pad_ff;
      wr_en    = 1'b0;
      wr_addr  = fill_ff;
      wr_data  = req_tdata;
      cmd      = '0;
      case (state_ff)
         ST_ACC: begin
            if (acc) begin
               if (req_tuser) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     cmd.start = 1'b1;
                     state_in  = ST_WAIT;
                  end
               end
               if (req_tlast) begin
                  last_in  = 1'b1;
                  pad_in   = 1'b1;
                  if (!(req_tuser && fill_ff == 6'd63)) begin
                     state_in = ST_PAD;
                  end
               end
            end
         end
         ST_WAIT: begin
            if (!eng_busy) begin
               state_in = last_ff ? ST_PAD : ST_ACC;
            end
         end
         ST_PAD: begin
            // Pad byte, then zeros up to the length field or block end.
            wr_en   = 1'b1;
            wr_data = (pad_ff) ? sha_pkg::PadByte : 8'h00;
            pad_in  = 1'b0;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'(sha_pkg::LenPos - 1)) begin
               state_in = ST_LEN;
            end else if (fill_ff == 6'd63) begin
               cmd.start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_LEN: begin
            wr_en   = 1'b1;
            wr_data = bits_ff[63 - 8*fill_ff[2:0] -: 8];
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) begin
               cmd.start     = 1'b1;
               cmd.final_blk = 1'b1;
               bits_in       = '0;
               last_in       = 1'b0;
               state_in      = ST_WAIT;
            end
         end
         default: state_in = ST_ACC;
      endcase
   end

   // ST_WAIT after the final block returns to ST_ACC: last_ff is clear then.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         fill_ff  <= '0;
         bits_ff  <= '0;
         last_ff  <= 1'b0;
         pad_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         bits_ff  <= bits_in;
         last_ff  <= last_in;
         pad_ff   <= pad_in;
      end
   end

   // Byte lanes of the block memory, one read port each.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_addr[1:0])
            2'd0:    mem0[wr_addr[5:2]] <= wr_data;
            2'd1:    mem1[wr_addr[5:2]] <= wr_data;
            2'd2:    mem2[wr_addr[5:2]] <= wr_data;
            default: mem3[wr_addr[5:2]] <= wr_data;
         endcase
      end
      rd0_ff <= mem0[eng_addr];
      rd1_ff <= mem1[eng_addr];
      rd2_ff <= mem2[eng_addr];
      rd3_ff <= mem3[eng_addr];
   end

   assign eng_word = {rd0_ff, rd1_ff, rd2_ff, rd3_ff};

endmodule

[rtl/core/sha256_stream_hasher.sv]
`timescale 1ns / 1ps
// SHA-256 over a byte stream. One byte is taken per cycle while a block
// fills; each 64-byte block then holds the input while the engine loads
// the schedule from the block memory and runs 64 rounds at one per cycle. On
// the end request the block pads and appends the length (one or two extra
// compressions) and sends eight digest words, most significant first.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // msg_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // digest_word
   output logic [2:0]  rsp_tuser,   // word_index
   output logic        rsp_tlast    // last_word
);

   sha_pkg::cmd_type cmd;
   logic [31:0]      blk_word;
   logic [3:0]       blk_addr;
   logic             busy;

   sha_buffer u_buf (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .req_tlast, .eng_busy(busy), .eng_addr(blk_addr), .eng_word(blk_word),
      .cmd
   );

   sha_round u_round (
      .clock, .reset, .cmd, .blk_word, .blk_addr, .busy,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

[rtl/core/sha_checker.sv]
`timescale 1ns / 1ps
`include "sha256_stream_hasher_defines.svh"
// Port-level checks on the hasher.
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `SHA_ASSERT_IMPL(a_last_idx, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tuser == 3'd7), "last flag mismatch")
   `SHA_ASSERT_IMPL(a_no_in_out, clock, reset, rsp_tvalid, !req_tready, "input open during digest")
   `SHA_ASSERT_NEXT(a_idx_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tuser == $past(rsp_tuser) + 3'd1, "word index skipped")
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled word changed")

endmodule

bind sha256_stream_hasher sha_checker u_chk (
   .clock, .reset, .req_tready, .rsp_tvalid, .rsp_tready,
   .rsp_tdata, .rsp_tuser, .rsp_tlast
);

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;

   // Digest word as the block presents it on the response channel.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_rsp_type;

   // One request: message byte with its valid and end flags.
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       eom;
   } byte_req_type;

   localparam int unsigned MaxCycles = 2000000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   byte_req_type   pending_reqs[$];
   digest_rsp_type expected_words[$];

   // Hash state kept by the predictor.
   logic [31:0] hash_state[8];
   logic [7:0]  block_bytes[64];
   int unsigned block_count;
   logic [63:0] bit_length;

   int unsigned error_count;
   int unsigned word_count;
   int unsigned message_count;
   int unsigned cycle_count;
   int unsigned idle_pct;
   bit          hold_sender;
   bit          req_taken;

   sha256_stream_hasher DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Run the 64 rounds over the current block and fold into the hash state.
   task automatic compress_block();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      end
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic restart_hash();
      hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                     32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      block_count = 0;
      bit_length  = '0;
   endtask

   // Predict the digest words that one accepted request produces.
   task automatic predict_digest(input byte_req_type r);
      digest_rsp_type d;
      if (r.valid) begin
         block_bytes[block_count] = r.data;
         block_count++;
         bit_length += 64'd8;
         if (block_count == 64) begin
            compress_block();
            block_count = 0;
         end
      end
      if (r.eom) begin
         block_bytes[block_count] = sha_pkg::PadByte;
         block_count++;
         if (block_count > sha_pkg::LenPos) begin
            while (block_count < 64) block_bytes[block_count++] = 8'h00;
            compress_block();
            block_count = 0;
         end
         while (block_count < sha_pkg::LenPos) block_bytes[block_count++] = 8'h00;
         for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_length[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            d.word  = hash_state[i];
            d.index = 3'(i);
            d.last  = (i == 7);
            expected_words.push_back(d);
         end
         restart_hash();
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // Queue a message of len bytes; random content unless fill_byte >= 0.
   task automatic add_message(input int len, input int fill_byte, input bit eom_on_byte);
      byte_req_type r;
      for (int i = 0; i < len; i++) begin
         r.data  = (fill_byte >= 0) ? 8'(fill_byte) : 8'($urandom);
         r.valid = 1'b1;
         r.eom   = eom_on_byte && (i == len - 1);
         pending_reqs.push_back(r);
      end
      if (!eom_on_byte || len == 0) begin
         r.data  = 8'($urandom);
         r.valid = 1'b0;
         r.eom   = 1'b1;
         pending_reqs.push_back(r);
      end
   endtask

   // Driver: present requests at the falling edge, idling at random, and stall the response channel at random.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_taken = 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // hold the current request until it is accepted
      end else begin
         req_taken = 1'b0;
         if (pending_reqs.size() > 0 && !hold_sender
             && $urandom_range(99, 0) >= idle_pct) begin
            req_tvalid <= 1'b1;
            {req_tdata, req_tuser, req_tlast} <= pending_reqs.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99, 0) >= idle_pct);
   end

   // Monitor: predict on accepted requests and check digest words.
   always @(posedge clock) begin
      digest_rsp_type want;
      if (!reset) begin
         cycle_count++;
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            predict_digest({req_tdata, req_tuser, req_tlast});
            if (req_tlast) message_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            word_count++;
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, 32'h0);
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want.word) report_mismatch("digest_word", rsp_tdata, want.word);
               if (rsp_tuser !== want.index)
                  report_mismatch("word_index", 32'(rsp_tuser), 32'(want.index));
               if (rsp_tlast !== want.last)
                  report_mismatch("last_word", 32'(rsp_tlast), 32'(want.last));
            end
         end
         if (cycle_count > MaxCycles) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      byte_req_type r;
      clock = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      req_tlast = 0;
      rsp_tready = 0;
      error_count = 0;
      word_count = 0;
      message_count = 0;
      cycle_count = 0;
      idle_pct = 24;
      hold_sender = 0;
      req_taken = 0;
      restart_hash();

      // Directed: empty message, an ignored item, short messages, and a
      // message whose pad byte lands on the last byte of a block.
      add_message(0, -1, 0);
      r = '{data: 8'hff, valid: 1'b0, eom: 1'b0};
      pending_reqs.push_back(r);
      add_message(3, 8'hff, 1);
      add_message(1, 8'h00, 0);
      add_message(63, -1, 0);

      repeat (5) @(posedge clock);
      reset <= 0;

      // Pause the sender until all digests are out.
      wait (pending_reqs.size() == 0);
      hold_sender = 1;
      wait (expected_words.size() == 0 && !req_tvalid);
      repeat (200) @(posedge clock);
      hold_sender = 0;

      // Random short messages, with a stretch of no idling in the middle.
      for (int m = 0; m < 6; m++) begin
         if (m == 2) begin
            wait (pending_reqs.size() == 0);
            idle_pct = 0;
         end
         if (m == 5) begin
            wait (pending_reqs.size() == 0);
            idle_pct = 24;
         end
         add_message($urandom_range(6, 0), -1, $urandom_range(1, 0));
         if ($urandom_range(3, 0) == 0) begin
            r.data = 8'($urandom);
            r.valid = 0;
            r.eom = 0;
            pending_reqs.push_back(r);
         end
      end

      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_words.size() == 0);
      repeat (300) @(posedge clock);
      $display("Covered %0d messages and %0d digest words, including empty,", message_count,
               word_count);
      $display("ignored items and block-boundary lengths under random stalls.");
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/sha_pkg.sv
rtl/core/sha_round.sv
rtl/core/sha_buffer.sv
rtl/core/sha256_stream_hasher.sv
rtl/core/sha_checker.sv
sim/tb.sv
